// ===== hdl/lzwb_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwb_pkg: shared types and constants for the LZW base64 image decoder
// Code and byte widths, dictionary geometry, entry layouts, sequencer states.
// ----------------------------------------------------------------------------
package lzwb_pkg;

    localparam int CODE_W        = 12;
    localparam int DICT_SIZE     = 1 << CODE_W;
    localparam int BYTE_W        = 8;
    localparam int LITERAL_COUNT = 1 << BYTE_W;
    localparam int MAX_STRING    = 64;
    localparam int STK_AW        = $clog2(MAX_STRING);
    localparam int LEN_W         = CODE_W;
    localparam int LEN_MAX       = (1 << LEN_W) - 1;
    localparam int NFC_W         = CODE_W + 1;
    localparam int ROW_W         = 16;
    localparam int ROW_WIDTH_RST = 256;
    localparam int B64_W         = 6;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;

    // prefix chain link: walked once per output byte
    typedef struct packed {
        code_t prefix;
        byte_t suffix;
    } chain_entry_t;

    // per-entry summary used when a new entry is built
    typedef struct packed {
        byte_t first;
        len_t  len;
    } info_entry_t;

    typedef struct packed {
        logic         en;
        code_t        addr;
        chain_entry_t chain;
        info_entry_t  info;
    } dict_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_WSTART,
        ST_WALK,
        ST_ESTART,
        ST_EMIT,
        ST_ERR
    } state_t;

endpackage

// ===== hdl/lzwb_b64.sv =====
// ----------------------------------------------------------------------------
// lzwb_b64: base64 character decoder
// Maps one ASCII character to its six-bit value; flags characters outside
// the alphabet and returns zero for them.
// ----------------------------------------------------------------------------
module lzwb_b64
(
    input  lzwb_pkg::byte_t                ch,
    output logic [lzwb_pkg::B64_W-1:0]     value,
    output logic                           bad
);

    always_comb
    begin
        bad   = 1'b0;
        value = '0;
        case (ch) inside
            ["A":"Z"]: value = lzwb_pkg::B64_W'(ch - 8'("A"));
            ["a":"z"]: value = lzwb_pkg::B64_W'(ch - 8'("a") + 8'd26);
            ["0":"9"]: value = lzwb_pkg::B64_W'(ch - 8'("0") + 8'd52);
            8'("+"):   value = lzwb_pkg::B64_W'(62);
            8'("/"):   value = lzwb_pkg::B64_W'(63);
            default:   bad   = 1'b1;
        endcase
    end

endmodule

// ===== hdl/lzwb_dict.sv =====
// ----------------------------------------------------------------------------
// lzwb_dict: LZW dictionary storage
// Chain memory (prefix, suffix) and info memory (first byte, length), one
// shared write port, one registered read port each.
// ----------------------------------------------------------------------------
module lzwb_dict
(
    input  logic                   clk,
    input  lzwb_pkg::dict_wr_t     wr,
    input  logic                   chain_rd_en,
    input  lzwb_pkg::code_t        chain_rd_addr,
    output lzwb_pkg::chain_entry_t chain_rd_data,
    input  logic                   info_rd_en,
    input  lzwb_pkg::code_t        info_rd_addr,
    output lzwb_pkg::info_entry_t  info_rd_data
);

    lzwb_pkg::chain_entry_t chain_mem [lzwb_pkg::DICT_SIZE];
    lzwb_pkg::info_entry_t  info_mem  [lzwb_pkg::DICT_SIZE];
    lzwb_pkg::chain_entry_t chain_rd_reg;
    lzwb_pkg::info_entry_t  info_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            chain_mem[wr.addr] <= wr.chain;
        end
        if (chain_rd_en)
        begin
            chain_rd_reg <= chain_mem[chain_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            info_mem[wr.addr] <= wr.info;
        end
        if (info_rd_en)
        begin
            info_rd_reg <= info_mem[info_rd_addr];
        end
    end

    assign chain_rd_data = chain_rd_reg;
    assign info_rd_data  = info_rd_reg;

endmodule

// ===== hdl/lzw_base64_image_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// lzw_base64_image_decoder_unit: LZW image decoder with base64 code input
// Joins two base64 characters into a 12-bit code, grows the dictionary and
// streams the code's string out as pixel bytes with end-of-row marks.
// ----------------------------------------------------------------------------
// Each input transaction carries one code and is worked on alone: the input
// is not ready again until the code's bytes are all queued for output. A
// code goes through a dictionary lookup and update, a walk of the prefix
// chain that does one dictionary read per byte, then one output transaction
// per cycle from a 64-byte stack while the output is ready. Strings longer
// than 64 bytes are cut and flagged. The final pixel sits in an output
// register, so the next code is taken while it still waits. row_width may
// only be written while the block is idle; 0 acts as 1.
// ----------------------------------------------------------------------------
module lzw_base64_image_decoder_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          start_of_image,
    input  lzwb_pkg::byte_t               char_high,
    input  lzwb_pkg::byte_t               char_low,

    output logic                          result_valid,
    input  logic                          result_ready,
    output lzwb_pkg::byte_t               pixel,
    output logic                          last_of_code,
    output logic                          end_of_row,
    output logic                          error,

    input  logic                          cfg_wr_en,
    input  logic [lzwb_pkg::ROW_W-1:0]    cfg_wr_data
);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    lzwb_pkg::state_t                  state_reg, state_next;
    logic                              have_prev_reg, have_prev_next;
    logic [lzwb_pkg::NFC_W-1:0]        nfc_reg, nfc_next;
    logic [lzwb_pkg::ROW_W-1:0]        col_reg, col_next;
    logic [lzwb_pkg::ROW_W-1:0]        row_width_reg, row_width_next;
    logic                              out_valid_reg, out_valid_next;
    logic [lzwb_pkg::STK_AW-1:0]       k_reg, k_next;

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    lzwb_pkg::code_t                   code_reg, code_next;
    logic                              bad_reg, bad_next;
    logic                              sof_reg, sof_next;
    lzwb_pkg::code_t                   prev_code_reg, prev_code_next;
    lzwb_pkg::len_t                    prev_len_reg, prev_len_next;
    lzwb_pkg::byte_t                   prev_first_reg, prev_first_next;
    lzwb_pkg::code_t                   cur_reg, cur_next;
    lzwb_pkg::len_t                    pos_reg, pos_next;
    lzwb_pkg::len_t                    zero_hi_reg, zero_hi_next;
    logic [lzwb_pkg::STK_AW-1:0]       count_m1_reg, count_m1_next;
    logic                              err_reg, err_next;
    lzwb_pkg::byte_t                   pixel_reg, pixel_next;
    logic                              last_reg, last_next;
    logic                              eor_reg, eor_next;
    logic                              error_reg, error_next;

    // ------------------------------------------------------------------
    // Character decode
    // ------------------------------------------------------------------
    logic [lzwb_pkg::B64_W-1:0]        hi_val, lo_val;
    logic                              hi_bad, lo_bad;

    lzwb_b64 u_b64_hi
    (
        .ch    (char_high),
        .value (hi_val),
        .bad   (hi_bad)
    );

    lzwb_b64 u_b64_lo
    (
        .ch    (char_low),
        .value (lo_val),
        .bad   (lo_bad)
    );

    // ------------------------------------------------------------------
    // Dictionary
    // ------------------------------------------------------------------
    lzwb_pkg::dict_wr_t                dict_wr;
    logic                              chain_rd_en;
    lzwb_pkg::code_t                   chain_rd_addr;
    lzwb_pkg::chain_entry_t            chain_rd;
    logic                              info_rd_en;
    lzwb_pkg::info_entry_t             info_rd;

    lzwb_dict u_dict
    (
        .clk           (clk),
        .wr            (dict_wr),
        .chain_rd_en   (chain_rd_en),
        .chain_rd_addr (chain_rd_addr),
        .chain_rd_data (chain_rd),
        .info_rd_en    (info_rd_en),
        .info_rd_addr  (code_reg),
        .info_rd_data  (info_rd)
    );

    // ------------------------------------------------------------------
    // Byte stack: chain walk fills it back to front, emit reads front to
    // back. Slots 1..zero_hi read as zero when the chain ends early, so no
    // clearing is needed between codes.
    // ------------------------------------------------------------------
    lzwb_pkg::byte_t                   stack_mem [lzwb_pkg::MAX_STRING];
    lzwb_pkg::byte_t                   stack_rd_reg;
    logic                              stk_wr_en;
    logic [lzwb_pkg::STK_AW-1:0]       stk_wr_addr;
    lzwb_pkg::byte_t                   stk_wr_data;
    logic                              stk_rd_en;
    logic [lzwb_pkg::STK_AW-1:0]       stk_rd_addr;

    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
        begin
            stack_mem[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_rd_en)
        begin
            stack_rd_reg <= stack_mem[stk_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer datapath helpers
    // ------------------------------------------------------------------
    logic                              code_lit;
    lzwb_pkg::len_t                    code_len;
    lzwb_pkg::byte_t                   code_first;
    lzwb_pkg::len_t                    plen;
    lzwb_pkg::code_t                   slot;
    logic                              code_is_slot;
    lzwb_pkg::len_t                    emit_len;
    lzwb_pkg::len_t                    pos_dec;
    logic                              out_free;
    logic [lzwb_pkg::ROW_W:0]          col_inc;
    logic [lzwb_pkg::ROW_W-1:0]        row_eff;
    logic                              row_done;

    assign code_lit     = (code_reg < lzwb_pkg::CODE_W'(lzwb_pkg::LITERAL_COUNT));
    assign code_len     = code_lit ? lzwb_pkg::LEN_W'(1) : info_rd.len;
    assign code_first   = code_lit ? code_reg[lzwb_pkg::BYTE_W-1:0] : info_rd.first;
    assign plen         = (prev_len_reg == lzwb_pkg::LEN_W'(lzwb_pkg::LEN_MAX))
                          ? prev_len_reg : prev_len_reg + lzwb_pkg::LEN_W'(1);
    assign slot         = nfc_reg[lzwb_pkg::CODE_W-1:0];
    assign code_is_slot = (code_reg == slot);
    assign pos_dec      = pos_reg - lzwb_pkg::LEN_W'(1);
    assign out_free     = !out_valid_reg || result_ready;

    // column tracking for end-of-row marks
    assign col_inc      = {1'b0, col_reg} + (lzwb_pkg::ROW_W + 1)'(1);
    assign row_eff      = (row_width_reg == '0) ? lzwb_pkg::ROW_W'(1) : row_width_reg;
    assign row_done     = (col_inc >= {1'b0, row_eff});

    // chain read follows the link just read while walking
    assign chain_rd_addr = (state_reg == lzwb_pkg::ST_WALK) ? chain_rd.prefix : cur_reg;

    // ------------------------------------------------------------------
    // Next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        have_prev_next  = have_prev_reg;
        nfc_next        = nfc_reg;
        col_next        = col_reg;
        row_width_next  = cfg_wr_en ? cfg_wr_data : row_width_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        k_next          = k_reg;

        code_next       = code_reg;
        bad_next        = bad_reg;
        sof_next        = sof_reg;
        prev_code_next  = prev_code_reg;
        prev_len_next   = prev_len_reg;
        prev_first_next = prev_first_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        zero_hi_next    = zero_hi_reg;
        count_m1_next   = count_m1_reg;
        err_next        = err_reg;
        pixel_next      = pixel_reg;
        last_next       = last_reg;
        eor_next        = eor_reg;
        error_next      = error_reg;

        emit_len        = code_len;
        item_ready      = 1'b0;
        info_rd_en      = 1'b0;
        chain_rd_en     = 1'b0;
        stk_wr_en       = 1'b0;
        stk_wr_addr     = '0;
        stk_wr_data     = '0;
        stk_rd_en       = 1'b0;
        stk_rd_addr     = '0;

        dict_wr.en          = 1'b0;
        dict_wr.addr        = slot;
        dict_wr.chain.prefix = prev_code_reg;
        dict_wr.chain.suffix = code_is_slot ? prev_first_reg : code_first;
        dict_wr.info.first  = prev_first_reg;
        dict_wr.info.len    = plen;

        case (state_reg)
            lzwb_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    code_next  = {hi_val, lo_val};
                    bad_next   = hi_bad | lo_bad;
                    sof_next   = start_of_image;
                    state_next = lzwb_pkg::ST_LOOKUP;
                end
            end

            lzwb_pkg::ST_LOOKUP:
            begin
                info_rd_en = 1'b1;
                state_next = lzwb_pkg::ST_DECIDE;
            end

            lzwb_pkg::ST_DECIDE:
            begin
                state_next = lzwb_pkg::ST_WSTART;
                if (sof_reg || !have_prev_reg)
                begin
                    // first code of an image: literal only
                    nfc_next       = lzwb_pkg::NFC_W'(lzwb_pkg::LITERAL_COUNT);
                    col_next       = '0;
                    have_prev_next = 1'b0;
                    if (!code_lit)
                    begin
                        state_next = lzwb_pkg::ST_ERR;
                    end
                    else
                    begin
                        have_prev_next = 1'b1;
                    end
                end
                else if (nfc_reg[lzwb_pkg::CODE_W])
                begin
                    // table full: wrap, no new entry
                    nfc_next = lzwb_pkg::NFC_W'(lzwb_pkg::LITERAL_COUNT);
                end
                else if ({1'b0, code_reg} > nfc_reg)
                begin
                    state_next = lzwb_pkg::ST_ERR;
                end
                else
                begin
                    dict_wr.en = 1'b1;
                    nfc_next   = nfc_reg + lzwb_pkg::NFC_W'(1);
                    if (code_is_slot)
                    begin
                        emit_len = plen;
                    end
                end

                if (state_next == lzwb_pkg::ST_WSTART)
                begin
                    prev_code_next  = code_reg;
                    prev_len_next   = emit_len;
                    prev_first_next = (dict_wr.en && code_is_slot) ? prev_first_reg
                                                                   : code_first;
                    cur_next        = code_reg;
                    pos_next        = emit_len;
                    zero_hi_next    = '0;
                    if (emit_len > lzwb_pkg::LEN_W'(lzwb_pkg::MAX_STRING))
                    begin
                        count_m1_next = lzwb_pkg::STK_AW'(lzwb_pkg::MAX_STRING - 1);
                        err_next      = 1'b1;
                    end
                    else
                    begin
                        count_m1_next = lzwb_pkg::STK_AW'(emit_len - lzwb_pkg::LEN_W'(1));
                        err_next      = bad_reg;
                    end
                    if (emit_len == '0)
                    begin
                        state_next = lzwb_pkg::ST_IDLE;
                    end
                end
            end

            lzwb_pkg::ST_WSTART:
            begin
                chain_rd_en = 1'b1;
                state_next  = lzwb_pkg::ST_WALK;
            end

            lzwb_pkg::ST_WALK:
            begin
                if (cur_reg < lzwb_pkg::CODE_W'(lzwb_pkg::LITERAL_COUNT))
                begin
                    // chain ends in a literal; it lands in slot 0
                    stk_wr_en    = 1'b1;
                    stk_wr_addr  = '0;
                    stk_wr_data  = cur_reg[lzwb_pkg::BYTE_W-1:0];
                    zero_hi_next = pos_dec;
                    state_next   = lzwb_pkg::ST_ESTART;
                end
                else
                begin
                    chain_rd_en = 1'b1;
                    stk_wr_en   = (pos_dec < lzwb_pkg::LEN_W'(lzwb_pkg::MAX_STRING));
                    stk_wr_addr = pos_dec[lzwb_pkg::STK_AW-1:0];
                    stk_wr_data = chain_rd.suffix;
                    cur_next    = chain_rd.prefix;
                    pos_next    = pos_dec;
                    if (pos_dec == '0)
                    begin
                        state_next = lzwb_pkg::ST_ESTART;
                    end
                end
            end

            lzwb_pkg::ST_ESTART:
            begin
                stk_rd_en   = 1'b1;
                stk_rd_addr = '0;
                k_next      = '0;
                state_next  = lzwb_pkg::ST_EMIT;
            end

            lzwb_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pixel_next     = ((k_reg != '0) &&
                                      (lzwb_pkg::LEN_W'(k_reg) <= zero_hi_reg))
                                     ? '0 : stack_rd_reg;
                    last_next      = (k_reg == count_m1_reg);
                    eor_next       = row_done;
                    col_next       = row_done ? '0 : col_inc[lzwb_pkg::ROW_W-1:0];
                    error_next     = err_reg;
                    if (k_reg == count_m1_reg)
                    begin
                        state_next = lzwb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next      = k_reg + lzwb_pkg::STK_AW'(1);
                        stk_rd_en   = 1'b1;
                        stk_rd_addr = k_reg + lzwb_pkg::STK_AW'(1);
                    end
                end
            end

            lzwb_pkg::ST_ERR:
            begin
                // single error transaction; column count untouched here
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pixel_next     = '0;
                    last_next      = 1'b1;
                    eor_next       = 1'b0;
                    error_next     = 1'b1;
                    state_next     = lzwb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lzwb_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzwb_pkg::ST_IDLE;
            have_prev_reg <= 1'b0;
            nfc_reg       <= lzwb_pkg::NFC_W'(lzwb_pkg::LITERAL_COUNT);
            col_reg       <= '0;
            row_width_reg <= lzwb_pkg::ROW_W'(lzwb_pkg::ROW_WIDTH_RST);
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            nfc_reg       <= nfc_next;
            col_reg       <= col_next;
            row_width_reg <= row_width_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg       <= code_next;
        bad_reg        <= bad_next;
        sof_reg        <= sof_next;
        prev_code_reg  <= prev_code_next;
        prev_len_reg   <= prev_len_next;
        prev_first_reg <= prev_first_next;
        cur_reg        <= cur_next;
        pos_reg        <= pos_next;
        zero_hi_reg    <= zero_hi_next;
        count_m1_reg   <= count_m1_next;
        err_reg        <= err_next;
        pixel_reg      <= pixel_next;
        last_reg       <= last_next;
        eor_reg        <= eor_next;
        error_reg      <= error_next;
    end

    assign result_valid = out_valid_reg;
    assign pixel        = pixel_reg;
    assign last_of_code = last_reg;
    assign end_of_row   = eor_reg;
    assign error        = error_reg;

endmodule
